[rtl/nsr_pkg.sv]
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared types and constants of the Newton-Raphson square root pipeline.
// ----------------------------------------------------------------------------
package nsr_pkg;

  localparam int unsigned RadicandW  = 32;
  localparam int unsigned RootW      = 25;
  localparam int unsigned CountOutW  = 5;
  localparam int unsigned TolW       = 16;

  localparam logic [TolW-1:0]  TolReset = TolW'(7);
  localparam logic [RootW-1:0] RootMax  = RootW'(1) << 24;

  typedef struct packed {
    logic done;
    logic exact;
    logic limit;
  } flags_t;

endpackage

[rtl/newton_square_root.sv]
// ----------------------------------------------------------------------------
// newton_square_root
// Newton-Raphson square root of an unsigned Q16.16 radicand.
// ----------------------------------------------------------------------------
// One radicand enters per cycle while the result side does not stall. Every
// Newton step is a chain of its own of stages (square, division setup, one
// stage per quotient bit of the restoring divider, update, square, stop
// tests), and an item that has converged rides through the remaining
// steps unchanged. A
// stall on the result side holds the whole pipeline. The tolerance register
// is taken at any cycle and must only change while no item is in flight.
module newton_square_root #(
  parameter int unsigned DATA_WIDTH     = 32,
  parameter int unsigned FRACTION_BITS  = 16,
  parameter int unsigned MAX_ITERATIONS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [nsr_pkg::TolW-1:0]          cfg_tolerance_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [nsr_pkg::RadicandW-1:0]     radicand_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [nsr_pkg::RootW-1:0]         root_o,
  output logic                              exact_hit_o,
  output logic                              limit_hit_o,
  output logic [nsr_pkg::CountOutW-1:0]     iteration_count_o
);

  localparam int unsigned XW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int unsigned AW = XW + FRACTION_BITS;
  localparam int unsigned CL = $clog2(MAX_ITERATIONS + 1);
  localparam int unsigned CW = (CL > nsr_pkg::CountOutW) ? CL : nsr_pkg::CountOutW;
  localparam int unsigned OW = (XW > nsr_pkg::RootW) ? XW : nsr_pkg::RootW;

  logic [nsr_pkg::TolW-1:0] tolerance_q;
  logic                     en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance_q <= nsr_pkg::TolReset;
    end else if (cfg_valid_i) begin
      tolerance_q <= cfg_tolerance_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  logic            ch_valid [MAX_ITERATIONS+1];
  nsr_pkg::flags_t ch_flags [MAX_ITERATIONS+1];
  logic [CW-1:0]   ch_count [MAX_ITERATIONS+1];
  logic [XW-1:0]   ch_x     [MAX_ITERATIONS+1];
  logic [AW-1:0]   ch_big   [MAX_ITERATIONS+1];

  logic [XW-1:0] a;

  always_comb begin
    a                 = radicand_i[XW-1:0];
    ch_valid[0]       = in_valid_i;
    ch_flags[0].done  = (a == '0);
    ch_flags[0].exact = (a == '0);
    ch_flags[0].limit = 1'b0;
    ch_count[0]       = '0;
    ch_x[0]           = a;
    ch_big[0]         = {a, {FRACTION_BITS{1'b0}}};
  end

  for (genvar i = 0; i < MAX_ITERATIONS; i++) begin : g_step
    nsr_step #(
      .XW       (XW),
      .FB       (FRACTION_BITS),
      .CW       (CW),
      .MAX_ITER (MAX_ITERATIONS)
    ) u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .tolerance_i (tolerance_q),
      .valid_i     (ch_valid[i]),
      .flags_i     (ch_flags[i]),
      .count_i     (ch_count[i]),
      .x_i         (ch_x[i]),
      .big_a_i     (ch_big[i]),
      .valid_o     (ch_valid[i+1]),
      .flags_o     (ch_flags[i+1]),
      .count_o     (ch_count[i+1]),
      .x_o         (ch_x[i+1]),
      .big_a_o     (ch_big[i+1])
    );
  end

  assign en          = !ch_valid[MAX_ITERATIONS] || !out_stall_i;
  assign in_stall_o  = !en;

  logic [OW-1:0] x_ext;

  always_comb begin
    x_ext  = OW'(ch_x[MAX_ITERATIONS]);
    root_o = (x_ext > OW'(nsr_pkg::RootMax)) ? nsr_pkg::RootMax
                                             : x_ext[nsr_pkg::RootW-1:0];
  end

  assign out_valid_o       = ch_valid[MAX_ITERATIONS];
  assign exact_hit_o       = ch_flags[MAX_ITERATIONS].exact;
  assign limit_hit_o       = ch_flags[MAX_ITERATIONS].limit;
  assign iteration_count_o = ch_count[MAX_ITERATIONS][nsr_pkg::CountOutW-1:0];

endmodule

[rtl/nsr_step.sv]
// ----------------------------------------------------------------------------
// nsr_step
// One fully pipelined Newton step: square, error magnitude, restoring
// division one quotient bit per stage, estimate update, square, stop tests.
// ----------------------------------------------------------------------------
module nsr_step #(
  parameter int unsigned XW       = 32,
  parameter int unsigned FB       = 16,
  parameter int unsigned CW       = 5,
  parameter int unsigned MAX_ITER = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [nsr_pkg::TolW-1:0]    tolerance_i,
  input  logic                        valid_i,
  input  nsr_pkg::flags_t             flags_i,
  input  logic [CW-1:0]               count_i,
  input  logic [XW-1:0]               x_i,
  input  logic [XW+FB-1:0]            big_a_i,
  output logic                        valid_o,
  output nsr_pkg::flags_t             flags_o,
  output logic [CW-1:0]               count_o,
  output logic [XW-1:0]               x_o,
  output logic [XW+FB-1:0]            big_a_o
);

  localparam int unsigned AW = XW + FB;
  localparam int unsigned MW = (AW > 2 * XW) ? AW : 2 * XW;
  localparam int unsigned SW = MW + 1;
  localparam logic [XW-1:0] XMax = {XW{1'b1}};

  typedef struct packed {
    nsr_pkg::flags_t flags;
    logic            active;
    logic            neg;
    logic            sat;
    logic [CW-1:0]   count;
    logic [XW-1:0]   x;
    logic [AW-1:0]   big;
    logic [MW-1:0]   r;
    logic [XW:0]     d;
    logic [XW-1:0]   q;
  } div_t;

  // square stage
  logic            a_valid_q;
  nsr_pkg::flags_t a_flags_q;
  logic [CW-1:0]   a_count_q;
  logic [XW-1:0]   a_x_q;
  logic [AW-1:0]   a_big_q;
  logic [2*XW-1:0] a_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_flags_q <= flags_i;
      a_count_q <= count_i;
      a_x_q     <= x_i;
      a_big_q   <= big_a_i;
      a_sq_q    <= (2*XW)'(x_i) * (2*XW)'(x_i);
    end
  end

  // error magnitude and division setup
  logic       dv_valid_q [XW+1];
  div_t       dv_q       [XW+1];
  div_t       dv_d       [XW+1];
  logic       zero_est;
  logic [MW-1:0] sq_ext, big_ext;

  always_comb begin
    zero_est  = !a_flags_q.done && (a_x_q == '0);
    sq_ext    = MW'(a_sq_q);
    big_ext   = MW'(a_big_q);
    dv_d[0]   = '0;
    dv_d[0].flags  = a_flags_q;
    dv_d[0].count  = a_count_q;
    dv_d[0].x      = a_x_q;
    dv_d[0].big    = a_big_q;
    dv_d[0].active = !a_flags_q.done && !zero_est;
    if (zero_est) begin
      dv_d[0].flags.done  = 1'b1;
      dv_d[0].flags.exact = (a_big_q == '0);
    end
    dv_d[0].neg = sq_ext < big_ext;
    dv_d[0].r   = dv_d[0].neg ? (big_ext - sq_ext) : (sq_ext - big_ext);
    dv_d[0].d   = {a_x_q, 1'b0};
    dv_d[0].sat = {1'b0, dv_d[0].r} >= (SW'(dv_d[0].d) << XW);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_valid_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_valid_q[0] <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q[0] <= dv_d[0];
    end
  end

  for (genvar j = 0; j < XW; j++) begin : g_div
    localparam int unsigned K = XW - 1 - j;
    logic [MW-1:0] cand;

    always_comb begin
      cand      = MW'(dv_q[j].d) << K;
      dv_d[j+1] = dv_q[j];
      if (dv_q[j].active && !dv_q[j].sat && (dv_q[j].r >= cand)) begin
        dv_d[j+1].r    = dv_q[j].r - cand;
        dv_d[j+1].q[K] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_valid_q[j+1] <= 1'b0;
      end else if (en_i) begin
        dv_valid_q[j+1] <= dv_valid_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[j+1] <= dv_d[j+1];
      end
    end
  end

  // estimate update
  logic            u_valid_q;
  nsr_pkg::flags_t u_flags_q;
  logic            u_active_q;
  logic [CW-1:0]   u_count_q;
  logic [XW-1:0]   u_x_q;
  logic [AW-1:0]   u_big_q;
  logic [XW-1:0]   u_diff_q;
  logic [XW:0]     sum;
  logic [XW-1:0]   nx_d, diff_d;
  logic [CW-1:0]   count_d;
  div_t            dl;

  always_comb begin
    dl      = dv_q[XW];
    sum     = {1'b0, dl.x} + {1'b0, dl.q};
    nx_d    = dl.x;
    count_d = dl.count;
    if (dl.active) begin
      count_d = dl.count + CW'(1);
      if (dl.neg) begin
        nx_d = (dl.sat || sum[XW]) ? XMax : sum[XW-1:0];
      end else begin
        nx_d = dl.x - dl.q;
      end
    end
    diff_d = (nx_d > dl.x) ? (nx_d - dl.x) : (dl.x - nx_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_valid_q <= 1'b0;
    end else if (en_i) begin
      u_valid_q <= dv_valid_q[XW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_flags_q  <= dl.flags;
      u_active_q <= dl.active;
      u_count_q  <= count_d;
      u_x_q      <= nx_d;
      u_big_q    <= dl.big;
      u_diff_q   <= diff_d;
    end
  end

  // square of the new estimate
  logic            m_valid_q;
  nsr_pkg::flags_t m_flags_q;
  logic            m_active_q;
  logic [CW-1:0]   m_count_q;
  logic [XW-1:0]   m_x_q;
  logic [AW-1:0]   m_big_q;
  logic [XW-1:0]   m_diff_q;
  logic [2*XW-1:0] m_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en_i) begin
      m_valid_q <= u_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_flags_q  <= u_flags_q;
      m_active_q <= u_active_q;
      m_count_q  <= u_count_q;
      m_x_q      <= u_x_q;
      m_big_q    <= u_big_q;
      m_diff_q   <= u_diff_q;
      m_sq_q     <= (2*XW)'(u_x_q) * (2*XW)'(u_x_q);
    end
  end

  // stop tests
  nsr_pkg::flags_t c_flags_d;
  logic            c_valid_q;
  nsr_pkg::flags_t c_flags_q;
  logic [CW-1:0]   c_count_q;
  logic [XW-1:0]   c_x_q;
  logic [AW-1:0]   c_big_q;
  logic [XW+nsr_pkg::TolW-1:0] diff_ext, tol_ext;

  always_comb begin
    c_flags_d = m_flags_q;
    diff_ext  = (XW+nsr_pkg::TolW)'(m_diff_q);
    tol_ext   = (XW+nsr_pkg::TolW)'(tolerance_i);
    if (m_active_q) begin
      if (MW'(m_sq_q) == MW'(m_big_q)) begin
        c_flags_d.exact = 1'b1;
        c_flags_d.done  = 1'b1;
      end else if (diff_ext <= tol_ext) begin
        c_flags_d.done  = 1'b1;
      end else if (m_count_q >= CW'(MAX_ITER)) begin
        c_flags_d.limit = 1'b1;
        c_flags_d.done  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      c_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_flags_q <= c_flags_d;
      c_count_q <= m_count_q;
      c_x_q     <= m_x_q;
      c_big_q   <= m_big_q;
    end
  end

  assign valid_o = c_valid_q;
  assign flags_o = c_flags_q;
  assign count_o = c_count_q;
  assign x_o     = c_x_q;
  assign big_a_o = c_big_q;

endmodule

[rtl/nsr_checker.sv]
// ----------------------------------------------------------------------------
// nsr_checker
// Port-level checks of the square root pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module nsr_checker #(
  parameter int unsigned MAX_ITERATIONS = 24
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [nsr_pkg::RootW-1:0]     root_o,
  input logic                          exact_hit_o,
  input logic                          limit_hit_o,
  input logic [nsr_pkg::CountOutW-1:0] iteration_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(root_o))
    else $error("stalled result changed");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(exact_hit_o && limit_hit_o))
    else $error("exact and limit both set");

  a_limit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && limit_hit_o |->
      iteration_count_o == nsr_pkg::CountOutW'(MAX_ITERATIONS % 32))
    else $error("limit without full iteration count");

  a_zero_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (iteration_count_o == '0) && (MAX_ITERATIONS < 32) |->
      exact_hit_o && (root_o == '0))
    else $error("no step done for a nonzero radicand");

endmodule

bind newton_square_root nsr_checker #(
  .MAX_ITERATIONS (MAX_ITERATIONS)
) u_nsr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .root_o            (root_o),
  .exact_hit_o       (exact_hit_o),
  .limit_hit_o       (limit_hit_o),
  .iteration_count_o (iteration_count_o)
);
